### rtl/tst_pkg.sv
package tst_pkg;

  // slot count and the size limit of a source
  localparam int NUM_SLOTS = 3;
  localparam int MAX_DIM   = 8192;
  localparam int SLOT_W    = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int PUSH_W    = (NUM_SLOTS < 3) ? NUM_SLOTS : 3;

  // field widths
  localparam int XY_W      = 15;
  localparam int SZ_W      = 14;
  localparam int DIM_W     = 14;
  localparam int BOX_W     = 20;
  localparam int SCALE_W   = 4;
  localparam int MAX_SCALE = 8;
  localparam int STRIDE_W  = 16;
  localparam int ROOM_W    = 2;
  localparam int REL_W     = 2;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;

  // row pitch: width rounded up to 64 pixels, 4 bytes per pixel
  localparam int ROW_ALIGN       = 63;
  localparam int BYTES_PER_PIXEL = 4;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP    = 2'd2;

  localparam logic [KIND_W-1:0] DMG_FULL = 2'd1;
  localparam logic [KIND_W-1:0] DMG_RECT = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_READY  = 2'd1,
    ST_QUEUED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_ALLOC
  } state_t;

  // beat layouts, first member in the highest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [REL_W-1:0]  released_slot;
    logic [ROOM_W-1:0] queue_room;
    logic              source_alpha;
    logic [DIM_W-1:0]  source_height;
    logic [DIM_W-1:0]  source_width;
    logic              source_present;
    logic [SZ_W-1:0]   damage_h;
    logic [SZ_W-1:0]   damage_w;
    logic [XY_W-1:0]   damage_y;
    logic [XY_W-1:0]   damage_x;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] damage_kind;
    logic [MODE_W-1:0] mode;
  } in_user_t;

  typedef struct packed {
    logic                pad;
    logic                work_pending;
    logic [2:0]          pushed_mask;
    logic [STRIDE_W-1:0] copy_stride;
    logic [DIM_W-1:0]    copy_h;
    logic [DIM_W-1:0]    copy_w;
    logic [DIM_W-1:0]    copy_y;
    logic [DIM_W-1:0]    copy_x;
    logic [1:0]          copy_slot;
    logic                copy_done;
  } out_item_t;

  localparam int IN_DATA_W  = $bits(in_item_t);
  localparam int IN_USER_W  = $bits(in_user_t);
  localparam int OUT_DATA_W = $bits(out_item_t);

  typedef struct packed {
    logic capture;
    logic merge;
    logic alloc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

### rtl/tst_ctrl.sv
module tst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tst_pkg::ctrl_sts_t  sts,
  output tst_pkg::ctrl_cmd_t  cmd
);
  import tst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_MERGE;
      end
      S_MERGE: begin
        state_next = S_ALLOC;
      end
      S_ALLOC: begin
        if (sts.out_free) state_next = s_tvalid ? S_MERGE : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // next beat is taken in the same cycle as the result is written
  always_comb begin
    s_tready    = 1'b0;
    cmd.merge   = 1'b0;
    cmd.alloc   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
      end
      S_ALLOC: begin
        s_tready  = sts.out_free;
        cmd.alloc = sts.out_free;
      end
      default: ;
    endcase
    cmd.capture = s_tvalid && s_tready;
  end

  a_capture_merge: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_MERGE)
    else $error("captured beat not followed by merge");

  a_merge_alloc: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |=> state == S_ALLOC)
    else $error("merge not followed by alloc");

endmodule

### rtl/tst_dp.sv
module tst_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tst_pkg::SCALE_W-1:0]      cfg_wr_data,
  input  tst_pkg::ctrl_cmd_t               cmd,
  output tst_pkg::ctrl_sts_t               sts,
  input  logic [tst_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [tst_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tst_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import tst_pkg::*;

  logic [SCALE_W-1:0] buffer_scale;

  // captured beat
  logic [MODE_W-1:0]        item_mode;
  logic [KIND_W-1:0]        item_kind;
  logic signed [XY_W-1:0]   item_dx;
  logic signed [XY_W-1:0]   item_dy;
  logic [SZ_W-1:0]          item_dw;
  logic [SZ_W-1:0]          item_dh;
  logic                     item_present;
  logic [DIM_W-1:0]         item_sw;
  logic [DIM_W-1:0]         item_sh;
  logic                     item_alpha;
  logic [ROOM_W-1:0]        item_room;
  logic [REL_W-1:0]         item_rel;

  // slot lanes
  slot_st_t                 slot_status      [NUM_SLOTS];
  slot_st_t                 slot_status_next [NUM_SLOTS];
  logic                     slot_sized       [NUM_SLOTS];
  logic                     slot_sized_next  [NUM_SLOTS];
  logic [DIM_W-1:0]         slot_width       [NUM_SLOTS];
  logic [DIM_W-1:0]         slot_width_next  [NUM_SLOTS];
  logic [DIM_W-1:0]         slot_height      [NUM_SLOTS];
  logic [DIM_W-1:0]         slot_height_next [NUM_SLOTS];
  logic                     slot_alpha       [NUM_SLOTS];
  logic                     slot_alpha_next  [NUM_SLOTS];
  logic                     slot_full        [NUM_SLOTS];
  logic                     slot_full_next   [NUM_SLOTS];
  logic                     slot_any         [NUM_SLOTS];
  logic                     slot_any_next    [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_x            [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_x_next       [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_y            [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_y_next       [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_w            [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_w_next       [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_h            [NUM_SLOTS];
  logic signed [BOX_W-1:0]  box_h_next       [NUM_SLOTS];
  logic                     retry;

  in_item_t  in_item;
  in_user_t  in_user;
  out_item_t out_item;

  assign in_item = in_item_t'(s_tdata);
  assign in_user = in_user_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_scale <= SCALE_W'(1);
    end else if (cfg_wr_en) begin
      buffer_scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode    <= in_user.mode;
      item_kind    <= in_user.damage_kind;
      item_dx      <= in_item.damage_x;
      item_dy      <= in_item.damage_y;
      item_dw      <= in_item.damage_w;
      item_dh      <= in_item.damage_h;
      item_present <= in_item.source_present;
      item_sw      <= (in_item.source_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                               : in_item.source_width;
      item_sh      <= (in_item.source_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                                : in_item.source_height;
      item_alpha   <= in_item.source_alpha;
      item_room    <= in_item.queue_room;
      item_rel     <= in_item.released_slot;
    end
  end

  // ---------------------------------------------------------------- merge
  logic [SCALE_W-1:0]        scale_eff;
  logic signed [BOX_W-1:0]   scale_s;
  logic signed [BOX_W-1:0]   dmg_x;
  logic signed [BOX_W-1:0]   dmg_y;
  logic signed [BOX_W-1:0]   dmg_w;
  logic signed [BOX_W-1:0]   dmg_h;
  logic signed [BOX_W:0]     dmg_x2;
  logic signed [BOX_W:0]     dmg_y2;
  logic                      rect_ok;
  logic signed [BOX_W-1:0]   un_x [NUM_SLOTS];
  logic signed [BOX_W-1:0]   un_y [NUM_SLOTS];
  logic signed [BOX_W-1:0]   un_w [NUM_SLOTS];
  logic signed [BOX_W-1:0]   un_h [NUM_SLOTS];

  always_comb begin
    if (buffer_scale == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (buffer_scale > SCALE_W'(MAX_SCALE)) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end else begin
      scale_eff = buffer_scale;
    end
  end

  assign scale_s = $signed({{(BOX_W-SCALE_W){1'b0}}, scale_eff});
  assign dmg_x   = $signed({{(BOX_W-XY_W){item_dx[XY_W-1]}}, item_dx}) * scale_s;
  assign dmg_y   = $signed({{(BOX_W-XY_W){item_dy[XY_W-1]}}, item_dy}) * scale_s;
  assign dmg_w   = $signed({{(BOX_W-SZ_W){1'b0}}, item_dw}) * scale_s;
  assign dmg_h   = $signed({{(BOX_W-SZ_W){1'b0}}, item_dh}) * scale_s;
  assign dmg_x2  = $signed({dmg_x[BOX_W-1], dmg_x}) + $signed({dmg_w[BOX_W-1], dmg_w});
  assign dmg_y2  = $signed({dmg_y[BOX_W-1], dmg_y}) + $signed({dmg_h[BOX_W-1], dmg_h});
  assign rect_ok = (item_kind == DMG_RECT) && (item_dw != '0) && (item_dh != '0);

  // bounding-box union, one lane per slot
  always_comb begin
    logic signed [BOX_W:0] old_x2;
    logic signed [BOX_W:0] old_y2;
    logic signed [BOX_W:0] max_x2;
    logic signed [BOX_W:0] max_y2;
    logic signed [BOX_W:0] span_x;
    logic signed [BOX_W:0] span_y;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      old_x2  = $signed({box_x[i][BOX_W-1], box_x[i]}) + $signed({box_w[i][BOX_W-1], box_w[i]});
      old_y2  = $signed({box_y[i][BOX_W-1], box_y[i]}) + $signed({box_h[i][BOX_W-1], box_h[i]});
      un_x[i] = (dmg_x < box_x[i]) ? dmg_x : box_x[i];
      un_y[i] = (dmg_y < box_y[i]) ? dmg_y : box_y[i];
      max_x2  = (dmg_x2 > old_x2) ? dmg_x2 : old_x2;
      max_y2  = (dmg_y2 > old_y2) ? dmg_y2 : old_y2;
      span_x  = max_x2 - $signed({un_x[i][BOX_W-1], un_x[i]});
      span_y  = max_y2 - $signed({un_y[i][BOX_W-1], un_y[i]});
      un_w[i] = span_x[BOX_W-1:0];
      un_h[i] = span_y[BOX_W-1:0];
    end
  end

  // ---------------------------------------------------------------- alloc
  logic                     is_tick;
  logic                     want;
  logic                     found;
  logic [SLOT_W-1:0]        k;
  logic                     resize;
  logic                     full_k;
  logic                     any_k;
  logic signed [BOX_W:0]    src_w_s;
  logic signed [BOX_W:0]    src_h_s;
  logic signed [BOX_W:0]    sel_x2;
  logic signed [BOX_W:0]    sel_y2;
  logic signed [BOX_W-1:0]  clip_x0;
  logic signed [BOX_W-1:0]  clip_y0;
  logic signed [BOX_W:0]    clip_x2;
  logic signed [BOX_W:0]    clip_y2;
  logic signed [BOX_W:0]    clip_w;
  logic signed [BOX_W:0]    clip_h;
  logic signed [BOX_W-1:0]  cp_x;
  logic signed [BOX_W-1:0]  cp_y;
  logic signed [BOX_W:0]    cp_w;
  logic signed [BOX_W:0]    cp_h;
  logic                     copy_ok;
  logic [DIM_W:0]           row_round;
  logic [DIM_W:0]           row_pix;
  logic [STRIDE_W-1:0]      stride;
  slot_st_t                 status_push [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     pushed_all;
  logic                     refused;
  logic                     retry_new;

  assign is_tick = (item_mode == MODE_TICK);
  assign want    = item_present && (item_sw != '0) && (item_sh != '0);

  always_comb begin
    found = 1'b0;
    k     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && slot_status[i] == ST_FREE) begin
        found = 1'b1;
        k     = SLOT_W'(i);
      end
    end
  end

  assign resize = !slot_sized[k] || (slot_width[k] != item_sw) ||
                  (slot_height[k] != item_sh) || (slot_alpha[k] != item_alpha);
  assign full_k = slot_full[k] || resize;
  assign any_k  = slot_any[k] || resize;

  assign src_w_s = $signed({{(BOX_W+1-DIM_W){1'b0}}, item_sw});
  assign src_h_s = $signed({{(BOX_W+1-DIM_W){1'b0}}, item_sh});
  assign sel_x2  = $signed({box_x[k][BOX_W-1], box_x[k]}) + $signed({box_w[k][BOX_W-1], box_w[k]});
  assign sel_y2  = $signed({box_y[k][BOX_W-1], box_y[k]}) + $signed({box_h[k][BOX_W-1], box_h[k]});
  assign clip_x0 = box_x[k][BOX_W-1] ? '0 : box_x[k];
  assign clip_y0 = box_y[k][BOX_W-1] ? '0 : box_y[k];
  assign clip_x2 = (sel_x2 > src_w_s) ? src_w_s : sel_x2;
  assign clip_y2 = (sel_y2 > src_h_s) ? src_h_s : sel_y2;
  assign clip_w  = clip_x2 - $signed({clip_x0[BOX_W-1], clip_x0});
  assign clip_h  = clip_y2 - $signed({clip_y0[BOX_W-1], clip_y0});

  // full damage, or a new size or format, copies the whole source
  assign cp_x = full_k ? '0 : clip_x0;
  assign cp_y = full_k ? '0 : clip_y0;
  assign cp_w = full_k ? src_w_s : clip_w;
  assign cp_h = full_k ? src_h_s : clip_h;

  assign copy_ok = is_tick && want && found && any_k && (cp_w > 0) && (cp_h > 0);

  assign row_round = {1'b0, item_sw} + (DIM_W+1)'(ROW_ALIGN);
  assign row_pix   = row_round & ~((DIM_W+1)'(ROW_ALIGN));
  assign stride    = STRIDE_W'(32'(row_pix) * BYTES_PER_PIXEL);

  // ready slots go to the queue in index order while room lasts
  always_comb begin
    logic [ROOM_W-1:0] room;
    slot_st_t          st_after;
    room       = item_room;
    refused    = 1'b0;
    pushed_all = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      st_after       = (copy_ok && k == SLOT_W'(i)) ? ST_READY : slot_status[i];
      status_push[i] = st_after;
      if (st_after == ST_READY) begin
        if (room != '0) begin
          status_push[i] = ST_QUEUED;
          room           = room - ROOM_W'(1);
          pushed_all[i]  = 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
    end
  end

  assign retry_new = (want && !found) || refused;

  // ---------------------------------------------------------------- slot update
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_status_next[i] = slot_status[i];
      slot_sized_next[i]  = slot_sized[i];
      slot_width_next[i]  = slot_width[i];
      slot_height_next[i] = slot_height[i];
      slot_alpha_next[i]  = slot_alpha[i];
      slot_full_next[i]   = slot_full[i];
      slot_any_next[i]    = slot_any[i];
      box_x_next[i]       = box_x[i];
      box_y_next[i]       = box_y[i];
      box_w_next[i]       = box_w[i];
      box_h_next[i]       = box_h[i];
    end

    if (cmd.merge) begin
      case (item_mode)
        MODE_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (item_kind == DMG_FULL) begin
              slot_full_next[i] = 1'b1;
              slot_any_next[i]  = 1'b1;
            end else if (rect_ok) begin
              if (!slot_any[i]) begin
                box_x_next[i]    = dmg_x;
                box_y_next[i]    = dmg_y;
                box_w_next[i]    = dmg_w;
                box_h_next[i]    = dmg_h;
                slot_any_next[i] = 1'b1;
              end else if (!slot_full[i]) begin
                box_x_next[i] = un_x[i];
                box_y_next[i] = un_y[i];
                box_w_next[i] = un_w[i];
                box_h_next[i] = un_h[i];
              end
            end
          end
        end
        MODE_RELEASE: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (32'(item_rel) == i) slot_status_next[i] = ST_FREE;
          end
        end
        MODE_DROP: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_status[i] == ST_READY) slot_status_next[i] = ST_FREE;
          end
        end
        default: ;
      endcase
    end

    if (cmd.alloc && is_tick) begin
      if (want && found) begin
        slot_sized_next[k]  = 1'b1;
        slot_width_next[k]  = item_sw;
        slot_height_next[k] = item_sh;
        slot_alpha_next[k]  = item_alpha;
        if (any_k) begin
          slot_full_next[k] = 1'b0;
          slot_any_next[k]  = 1'b0;
          box_x_next[k]     = '0;
          box_y_next[k]     = '0;
          box_w_next[k]     = '0;
          box_h_next[k]     = '0;
        end else begin
          slot_full_next[k] = full_k;
          slot_any_next[k]  = any_k;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_status_next[i] = status_push[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_status[i] <= ST_FREE;
        slot_sized[i]  <= 1'b0;
        slot_full[i]   <= 1'b0;
        slot_any[i]    <= 1'b0;
      end
      retry <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_status[i] <= slot_status_next[i];
        slot_sized[i]  <= slot_sized_next[i];
        slot_full[i]   <= slot_full_next[i];
        slot_any[i]    <= slot_any_next[i];
      end
      if (cmd.alloc && is_tick) retry <= retry_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_width[i]  <= slot_width_next[i];
      slot_height[i] <= slot_height_next[i];
      slot_alpha[i]  <= slot_alpha_next[i];
      box_x[i]       <= box_x_next[i];
      box_y[i]       <= box_y_next[i];
      box_w[i]       <= box_w_next[i];
      box_h[i]       <= box_h_next[i];
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    out_item              = '0;
    out_item.copy_done    = copy_ok;
    out_item.work_pending = is_tick ? retry_new : retry;
    if (copy_ok) begin
      out_item.copy_slot   = 2'(k);
      out_item.copy_x      = cp_x[DIM_W-1:0];
      out_item.copy_y      = cp_y[DIM_W-1:0];
      out_item.copy_w      = cp_w[DIM_W-1:0];
      out_item.copy_h      = cp_h[DIM_W-1:0];
      out_item.copy_stride = stride;
    end
    if (is_tick) out_item.pushed_mask = 3'(pushed_all[PUSH_W-1:0]);
  end

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.alloc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) m_tdata <= OUT_DATA_W'(out_item);
  end

  a_alloc_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> m_tvalid)
    else $error("result not presented after alloc");

  a_no_push_off_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc && !is_tick |-> !copy_ok && out_item.pushed_mask == '0)
    else $error("copy or push outside a tick");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> sts.out_free)
    else $error("result written over a waiting beat");

endmodule

### rtl/triple_slot_damage_tracker.sv
// Each accepted beat passes the merge state, then the allocate/push state, whose
//   write registers its result onto m_tvalid and takes the next beat; that state
//   waits only while the output register holds a result not yet taken.
// Reset (rst, synchronous): all slots free, unallocated and clean, retry clear,
//   buffer_scale back to 1, no result pending.
module triple_slot_damage_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tst_pkg::SCALE_W-1:0]       cfg_wr_data,   // buffer_scale
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // damage_x, damage_y, damage_w, damage_h, source_present, source_width,
  // source_height, source_alpha, queue_room, released_slot, zero pad
  input  logic [tst_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [tst_pkg::IN_USER_W-1:0]     s_tuser,       // mode, damage_kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // copy_done, copy_slot, copy_x, copy_y, copy_w, copy_h, copy_stride,
  // pushed_mask, work_pending, zero pad
  output logic [tst_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import tst_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tst_pkg::*;

  localparam logic [KIND_W-1:0] DMG_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] DMG_BAD     = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [SCALE_W-1:0]    cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // damage_x, damage_y, damage_w, damage_h, source_present, source_width,
  // source_height, source_alpha, queue_room, released_slot, zero pad
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;  // mode, damage_kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // copy_done, copy_slot, copy_x, copy_y, copy_w, copy_h, copy_stride,
  // pushed_mask, work_pending, zero pad
  logic [OUT_DATA_W-1:0] m_tdata;

  triple_slot_damage_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tracker state as the block should hold it
  logic [SCALE_W-1:0]      scale_reg;
  slot_st_t                slot_state [NUM_SLOTS];
  bit                      slot_sized [NUM_SLOTS];
  logic [DIM_W-1:0]        slot_w     [NUM_SLOTS];
  logic [DIM_W-1:0]        slot_h     [NUM_SLOTS];
  bit                      slot_alpha [NUM_SLOTS];
  bit                      whole_dirty [NUM_SLOTS];
  bit                      any_dirty  [NUM_SLOTS];
  logic signed [BOX_W-1:0] box_x      [NUM_SLOTS];
  logic signed [BOX_W-1:0] box_y      [NUM_SLOTS];
  logic signed [BOX_W-1:0] box_w      [NUM_SLOTS];
  logic signed [BOX_W-1:0] box_h      [NUM_SLOTS];
  bit                      retry;

  out_item_t   due_reports [$];
  int          failures = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;

  function automatic void reset_tracker();
    scale_reg = SCALE_W'(1);
    retry = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_state[i] = ST_FREE;
      slot_sized[i] = 1'b0;
      slot_w[i] = '0;
      slot_h[i] = '0;
      slot_alpha[i] = 1'b0;
      whole_dirty[i] = 1'b0;
      any_dirty[i] = 1'b0;
      box_x[i] = '0;
      box_y[i] = '0;
      box_w[i] = '0;
      box_h[i] = '0;
    end
  endfunction

  // grow one slot's damage box by the scaled damage of this tick
  function automatic void fold_damage(int i, logic [KIND_W-1:0] kind,
                                      int x, int y, int w, int h);
    int x2, y2;
    if (kind == DMG_FULL) begin
      whole_dirty[i] = 1'b1;
      any_dirty[i] = 1'b1;
      return;
    end
    if (kind != DMG_RECT || w <= 0 || h <= 0) return;
    if (!any_dirty[i]) begin
      box_x[i] = BOX_W'(x);
      box_y[i] = BOX_W'(y);
      box_w[i] = BOX_W'(w);
      box_h[i] = BOX_W'(h);
      any_dirty[i] = 1'b1;
      return;
    end
    if (whole_dirty[i]) return;
    x2 = box_x[i] + box_w[i];
    y2 = box_y[i] + box_h[i];
    if (x < box_x[i]) box_x[i] = BOX_W'(x);
    if (y < box_y[i]) box_y[i] = BOX_W'(y);
    if (x + w > x2) x2 = x + w;
    if (y + h > y2) y2 = y + h;
    box_w[i] = BOX_W'(x2 - box_x[i]);
    box_h[i] = BOX_W'(y2 - box_y[i]);
  endfunction

  function automatic out_item_t track_slots(in_user_t u, in_item_t d);
    out_item_t r;
    int scl, dx, dy, dw, dh, sw, sh, room, pick, x0, y0, x2, y2, cw, ch;
    r = '0;
    pick = -1;
    cw = 0;
    ch = 0;
    case (u.mode)
      MODE_RELEASE: if (d.released_slot < NUM_SLOTS) slot_state[d.released_slot] = ST_FREE;
      MODE_DROP: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_state[i] == ST_READY) slot_state[i] = ST_FREE;
      end
      MODE_TICK: begin
        scl = int'(scale_reg);
        if (scl < 1) scl = 1;
        if (scl > MAX_SCALE) scl = MAX_SCALE;
        dx = int'($signed(d.damage_x)) * scl;
        dy = int'($signed(d.damage_y)) * scl;
        dw = int'(d.damage_w) * scl;
        dh = int'(d.damage_h) * scl;
        sw = int'(d.source_width);
        sh = int'(d.source_height);
        if (sw > MAX_DIM) sw = MAX_DIM;
        if (sh > MAX_DIM) sh = MAX_DIM;
        room = int'(d.queue_room);
        retry = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) fold_damage(i, u.damage_kind, dx, dy, dw, dh);
        if (d.source_present && sw != 0 && sh != 0) begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (pick < 0 && slot_state[i] == ST_FREE) pick = i;
          if (pick < 0) begin
            retry = 1'b1;
          end else begin
            // new geometry or format: reallocate, whole slot dirty
            if (!slot_sized[pick] || slot_w[pick] != sw || slot_h[pick] != sh ||
                slot_alpha[pick] != d.source_alpha) begin
              slot_sized[pick] = 1'b1;
              slot_w[pick] = DIM_W'(sw);
              slot_h[pick] = DIM_W'(sh);
              slot_alpha[pick] = d.source_alpha;
              whole_dirty[pick] = 1'b1;
              any_dirty[pick] = 1'b1;
            end
            if (any_dirty[pick]) begin
              if (whole_dirty[pick]) begin
                x0 = 0;
                y0 = 0;
                cw = sw;
                ch = sh;
              end else begin
                x2 = box_x[pick] + box_w[pick];
                y2 = box_y[pick] + box_h[pick];
                x0 = (box_x[pick] < 0) ? 0 : box_x[pick];
                y0 = (box_y[pick] < 0) ? 0 : box_y[pick];
                if (x2 > sw) x2 = sw;
                if (y2 > sh) y2 = sh;
                cw = x2 - x0;
                ch = y2 - y0;
              end
              any_dirty[pick] = 1'b0;
              whole_dirty[pick] = 1'b0;
              box_x[pick] = '0;
              box_y[pick] = '0;
              box_w[pick] = '0;
              box_h[pick] = '0;
              if (cw > 0 && ch > 0) begin
                slot_state[pick] = ST_READY;
                r.copy_done = 1'b1;
                r.copy_slot = 2'(pick);
                r.copy_x = DIM_W'(x0);
                r.copy_y = DIM_W'(y0);
                r.copy_w = DIM_W'(cw);
                r.copy_h = DIM_W'(ch);
                r.copy_stride = STRIDE_W'(((sw + ROW_ALIGN) & ~ROW_ALIGN) * BYTES_PER_PIXEL);
              end
            end
          end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_state[i] == ST_READY) begin
            if (room > 0) begin
              slot_state[i] = ST_QUEUED;
              room--;
              if (i < 3) r.pushed_mask[i] = 1'b1;
            end else begin
              retry = 1'b1;
            end
          end
        end
      end
      default: ;  // unused mode leaves everything alone
    endcase
    r.work_pending = retry;
    return r;
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    out_item_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = out_item_t'(m_tdata);
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected beat expected none got %h", $time, m_tdata);
        failures++;
      end else begin
        want = due_reports.pop_front();
        cmp_field("copy_done", 32'(want.copy_done), 32'(got.copy_done));
        cmp_field("copy_slot", 32'(want.copy_slot), 32'(got.copy_slot));
        cmp_field("copy_x", 32'(want.copy_x), 32'(got.copy_x));
        cmp_field("copy_y", 32'(want.copy_y), 32'(got.copy_y));
        cmp_field("copy_w", 32'(want.copy_w), 32'(got.copy_w));
        cmp_field("copy_h", 32'(want.copy_h), 32'(got.copy_h));
        cmp_field("copy_stride", 32'(want.copy_stride), 32'(got.copy_stride));
        cmp_field("pushed_mask", 32'(want.pushed_mask), 32'(got.pushed_mask));
        cmp_field("work_pending", 32'(want.work_pending), 32'(got.work_pending));
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (sink_hold > 0) sink_hold = sink_hold - 1;
    else if (sink_idle_on && $urandom_range(0, 9) == 0) sink_hold = $urandom_range(1, 19);
    m_tready <= (sink_hold == 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(in_user_t u, in_item_t d);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= u;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    due_reports.push_back(track_slots(u, d));
  endtask

  task automatic send_tick(logic [KIND_W-1:0] kind, int x, int y, int w, int h,
                           bit present, int sw, int sh, bit alpha, int room);
    in_item_t d;
    d = '0;
    d.damage_x = x[XY_W-1:0];
    d.damage_y = y[XY_W-1:0];
    d.damage_w = w[SZ_W-1:0];
    d.damage_h = h[SZ_W-1:0];
    d.source_present = present;
    d.source_width = sw[DIM_W-1:0];
    d.source_height = sh[DIM_W-1:0];
    d.source_alpha = alpha;
    d.queue_room = room[ROOM_W-1:0];
    d.released_slot = REL_W'($urandom_range(0, 3));
    send_beat(in_user_t'{damage_kind: kind, mode: MODE_TICK}, d);
  endtask

  // release, drop and unused beats carry junk in every other field, with the pad kept zero
  task automatic send_other(logic [MODE_W-1:0] mode, logic [REL_W-1:0] slot);
    in_item_t d;
    d = {$urandom, $urandom, $urandom};
    d.pad = '0;
    d.released_slot = slot;
    send_beat(in_user_t'{damage_kind: KIND_W'($urandom_range(0, 3)), mode: mode}, d);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_reg = v;
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 8192;
      2:       return $urandom_range(0, 16383);
      3, 4:    return 64;
      default: return $urandom_range(1, 700);
    endcase
  endfunction

  task automatic test_slot_lifecycle();
    send_tick(DMG_FULL, 0, 0, 0, 0, 1, 64, 32, 0, 3);
    send_tick(DMG_RECT, 10, 5, 20, 10, 1, 64, 32, 0, 0);     // new slot, no queue room
    send_other(MODE_RELEASE, 0);
    send_tick(DMG_NONE, 0, 0, 0, 0, 1, 64, 32, 0, 1);        // box copy, one push only
    send_other(MODE_DROP, 0);
    send_other(MODE_RELEASE, 3);                            // no such slot
    send_other(MODE_UNUSED, 1);
    send_tick(DMG_BAD, 5, 5, 5, 5, 1, 64, 32, 0, 3);         // clean slot, nothing to copy
    send_tick(DMG_RECT, 3, 3, 0, 9, 1, 64, 32, 0, 3);        // zero width ignored
    send_tick(DMG_RECT, -16384, -16384, 16383, 16383, 1, 8192, 8192, 1, 3);
    send_other(MODE_RELEASE, 1);
    send_tick(DMG_NONE, 0, 0, 0, 0, 1, 16383, 16383, 1, 3); // saturates to the size limit
    send_other(MODE_RELEASE, 1);
    send_tick(DMG_RECT, -16384, -16384, 16383, 16383, 1, 16383, 16383, 1, 3);
    send_tick(DMG_RECT, 16383, 16383, 16383, 16383, 1, 8192, 8192, 1, 3);
    send_tick(DMG_RECT, 8000, -5, 500, 100, 1, 8192, 8192, 1, 3);
    send_tick(DMG_FULL, 0, 0, 0, 0, 1, 64, 32, 0, 3);        // every slot queued
    send_other(MODE_RELEASE, 2);
    send_tick(DMG_NONE, 0, 0, 0, 0, 1, 0, 32, 0, 3);
    send_tick(DMG_RECT, 1, 1, 4, 4, 0, 64, 32, 0, 3);
    send_other(MODE_RELEASE, 0);
    send_tick(DMG_NONE, 0, 0, 0, 0, 1, 64, 32, 0, 0);
    send_other(MODE_DROP, 2);
  endtask

  task automatic run_traffic(int count, bit bursty);
    int sw, sh, roll, x, y, w, h;
    bit alpha;
    logic [KIND_W-1:0] kind;
    logic [REL_W-1:0] slot;
    int queued_ids [$];
    sw = pick_size();
    sh = pick_size();
    alpha = 1'($urandom_range(0, 1));
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        src_idle_on = bursty && $urandom_range(0, 3) != 0;
        sink_idle_on = bursty && $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < 4) begin
        sw = pick_size();
        sh = pick_size();
      end
      if ($urandom_range(0, 99) < 3) alpha = !alpha;
      if (bursty && $urandom_range(0, 99) == 0) settle();
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
        roll = $urandom_range(0, 99);
        kind = (roll < 70) ? DMG_RECT : (roll < 82) ? DMG_FULL : (roll < 96) ? DMG_NONE : DMG_BAD;
        if ($urandom_range(0, 6) == 0) begin
          x = int'($urandom_range(0, 32767)) - 16384;
          y = int'($urandom_range(0, 32767)) - 16384;
          w = $urandom_range(0, 16383);
          h = $urandom_range(0, 16383);
        end else begin
          x = int'($urandom_range(0, 400)) - 40;
          y = int'($urandom_range(0, 400)) - 40;
          w = $urandom_range(0, 160);
          h = $urandom_range(0, 160);
        end
        send_tick(kind, x, y, w, h, $urandom_range(0, 24) != 0, sw, sh, alpha,
                  $urandom_range(0, 3));
      end else if (roll < 88) begin
        queued_ids = {};
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_state[i] == ST_QUEUED) queued_ids.push_back(i);
        if (queued_ids.size() != 0 && $urandom_range(0, 6) != 0)
          slot = REL_W'(queued_ids[$urandom_range(0, queued_ids.size() - 1)]);
        else
          slot = REL_W'($urandom_range(0, 3));
        send_other(MODE_RELEASE, slot);
      end else if (roll < 95) begin
        send_other(MODE_DROP, REL_W'($urandom_range(0, 3)));
      end else if (roll < 97) begin
        send_other(MODE_UNUSED, REL_W'($urandom_range(0, 3)));
      end else begin
        // noise: any value each field can hold
        send_tick(KIND_W'($urandom_range(0, 3)), int'($urandom_range(0, 32767)) - 16384,
                  int'($urandom_range(0, 32767)) - 16384, $urandom_range(0, 16383),
                  $urandom_range(0, 16383), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 16383), $urandom_range(0, 16383),
                  1'($urandom_range(0, 1)), $urandom_range(0, 3));
      end
    end
  endtask

  task automatic test_scale_settings();
    write_scale(SCALE_W'(8));
    run_traffic(280, 1'b1);
    write_scale(SCALE_W'(0));   // acts as 1
    run_traffic(260, 1'b1);
    write_scale(SCALE_W'(15));  // clamps to 8
    run_traffic(260, 1'b1);
    write_scale(SCALE_W'(1));
    run_traffic(280, 1'b1);
    write_scale(SCALE_W'($urandom_range(2, 7)));
    run_traffic(290, 1'b1);
  endtask

  task automatic test_unpaced_traffic();
    write_scale(SCALE_W'($urandom_range(1, 8)));
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_traffic(260, 1'b0);
  endtask

  initial begin
    reset_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    test_slot_lifecycle();
    test_scale_settings();
    test_unpaced_traffic();
    settle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
